/* hdl/nfcpl_pkg.sv */
// Shared types, codes and helpers for the NFC poll protocol lock.
package nfcpl_pkg;

  localparam int unsigned CtrW  = 4;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [CtrW-1:0] CtrMax = 4'd15;

  typedef enum logic {
    PROTO_F = 1'b0,
    PROTO_A = 1'b1
  } proto_e;

  typedef enum logic [1:0] {
    KIND_TAG   = 2'd0,
    KIND_NOTAG = 2'd1,
    KIND_NOOBS = 2'd2
  } kind_e;

  // Raw outcome code that folds onto no observation
  localparam logic [1:0] OutcomeSpare = 2'd3;

  typedef enum logic [1:0] {
    LOCK_NONE = 2'd0,
    LOCK_F    = 2'd1,
    LOCK_A    = 2'd2
  } lock_e;

  typedef enum logic [1:0] {
    PH_FIRST    = 2'd0,
    PH_SECOND   = 2'd1,
    PH_FALLBACK = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    REG_LOCK_RELEASE = 2'd0,
    REG_F_CLEAN      = 2'd1,
    REG_F_NOISY      = 2'd2
  } reg_idx_e;

  localparam logic [CtrW-1:0] LockReleaseRst = 4'd3;
  localparam logic [CtrW-1:0] FCleanRst      = 4'd2;
  localparam logic [CtrW-1:0] FNoisyRst      = 4'd3;

  typedef struct packed {
    logic [CtrW-1:0] lock_release_count;
    logic [CtrW-1:0] f_clean_absence_count;
    logic [CtrW-1:0] f_noisy_fallback_count;
  } cfg_t;

  typedef struct packed {
    lock_e           locked_proto;
    proto_e          probe_proto;
    phase_e          sub_phase;
    logic [CtrW-1:0] lock_absence_ctr;
    logic [CtrW-1:0] f_absence_ctr;
    logic [CtrW-1:0] f_noisy_ctr;
    logic            first_was_noisy;
  } state_t;

  typedef struct packed {
    proto_e next_protocol;
    logic   call_done;
    kind_e  reported_kind;
    lock_e  lock_status;
  } res_t;

  function automatic logic [CtrW-1:0] sat_inc(input logic [CtrW-1:0] v);
    return (v == CtrMax) ? CtrMax : v + 1'b1;
  endfunction

endpackage

/* hdl/nfcpl_if.sv */
// Valid/ready channels for poll requests and lock results.
interface nfcpl_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [1:0] poll_outcome;

  modport source (output valid, output req_type, output poll_outcome, input ready);
  modport sink   (input valid, input req_type, input poll_outcome, output ready);
endinterface

interface nfcpl_res_if;
  logic       valid;
  logic       ready;
  logic       next_protocol;
  logic       call_done;
  logic [1:0] reported_kind;
  logic [1:0] lock_status;

  modport source (output valid, output next_protocol, output call_done,
                  output reported_kind, output lock_status, input ready);
  modport sink   (input valid, input next_protocol, input call_done,
                  input reported_kind, input lock_status, output ready);
endinterface

/* hdl/nfcpl_core.sv */
// Lock state register and the per-beat decision logic.
module nfcpl_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nfcpl_pkg::cfg_t cfg_i,
  input  logic            step_i,
  input  logic            req_type_i,
  input  logic [1:0]      poll_outcome_i,
  output nfcpl_pkg::res_t res_o
);
  import nfcpl_pkg::*;

  state_t          state_q, state_d;
  kind_e           oc;
  kind_e           kind;
  logic            done;
  proto_e          polled;
  logic [CtrW-1:0] ctr_inc;

  always_comb begin
    state_d = state_q;
    done    = 1'b0;
    kind    = KIND_TAG;
    polled  = PROTO_F;
    ctr_inc = '0;
    oc      = (poll_outcome_i == OutcomeSpare) ? KIND_NOOBS : kind_e'(poll_outcome_i);

    if (req_type_i) begin
      state_d = '0;
    end else if (state_q.sub_phase == PH_SECOND || state_q.sub_phase == PH_FALLBACK) begin
      polled = (state_q.sub_phase == PH_SECOND) ? proto_e'(~state_q.probe_proto) : PROTO_A;
      done   = 1'b1;
      state_d.lock_absence_ctr = '0;
      state_d.f_absence_ctr    = '0;
      state_d.f_noisy_ctr      = '0;
      if (oc == KIND_TAG) begin
        state_d.locked_proto = (polled == PROTO_A) ? LOCK_A : LOCK_F;
        state_d.probe_proto  = polled;
        kind = KIND_TAG;
      end else begin
        state_d.probe_proto = PROTO_F;
        if (state_q.sub_phase == PH_SECOND) begin
          kind = (state_q.first_was_noisy || oc == KIND_NOOBS) ? KIND_NOOBS : KIND_NOTAG;
        end else begin
          kind = oc;
        end
      end
      state_d.sub_phase = PH_FIRST;
    end else if (state_q.locked_proto == LOCK_F || state_q.locked_proto == LOCK_A) begin
      done = 1'b1;
      kind = oc;
      case (oc)
        KIND_TAG: begin
          state_d.lock_absence_ctr = '0;
          state_d.f_absence_ctr    = '0;
          state_d.f_noisy_ctr      = '0;
        end
        KIND_NOOBS: begin
          state_d.lock_absence_ctr = '0;
          state_d.f_absence_ctr    = '0;
          if (state_q.locked_proto == LOCK_F) begin
            ctr_inc = sat_inc(state_q.f_noisy_ctr);
            state_d.f_noisy_ctr = ctr_inc;
            // Too noisy on F: drop the lock and try A once
            if (ctr_inc >= cfg_i.f_noisy_fallback_count) begin
              state_d.locked_proto = LOCK_NONE;
              state_d.sub_phase    = PH_FALLBACK;
              done = 1'b0;
            end
          end
        end
        default: begin
          state_d.f_noisy_ctr = '0;
          ctr_inc = sat_inc(state_q.lock_absence_ctr);
          state_d.lock_absence_ctr = ctr_inc;
          if (ctr_inc >= cfg_i.lock_release_count) begin
            state_d.locked_proto     = LOCK_NONE;
            state_d.probe_proto      = PROTO_F;
            state_d.lock_absence_ctr = '0;
            state_d.f_absence_ctr    = '0;
            state_d.f_noisy_ctr      = '0;
          end
        end
      endcase
    end else begin
      state_d.locked_proto = LOCK_NONE;
      state_d.sub_phase    = PH_FIRST;
      if (oc == KIND_TAG) begin
        state_d.locked_proto     = (state_q.probe_proto == PROTO_A) ? LOCK_A : LOCK_F;
        state_d.lock_absence_ctr = '0;
        state_d.f_absence_ctr    = '0;
        state_d.f_noisy_ctr      = '0;
        done = 1'b1;
        kind = KIND_TAG;
      end else if (state_q.probe_proto == PROTO_F && oc == KIND_NOOBS) begin
        ctr_inc = sat_inc(state_q.f_noisy_ctr);
        state_d.f_noisy_ctr = ctr_inc;
        if (ctr_inc < cfg_i.f_noisy_fallback_count) begin
          state_d.f_absence_ctr = '0;
          done = 1'b1;
          kind = KIND_NOOBS;
        end else begin
          state_d.sub_phase = PH_FALLBACK;
        end
      end else begin
        if (state_q.probe_proto == PROTO_F) begin
          state_d.f_noisy_ctr = '0;
          ctr_inc = sat_inc(state_q.f_absence_ctr);
          state_d.f_absence_ctr = ctr_inc;
        end
        // Hold on F until enough clean absences, then probe the other protocol
        if (state_q.probe_proto == PROTO_F && ctr_inc < cfg_i.f_clean_absence_count) begin
          done = 1'b1;
          kind = KIND_NOTAG;
        end else begin
          state_d.first_was_noisy = (oc == KIND_NOOBS);
          state_d.sub_phase       = PH_SECOND;
        end
      end
    end

    res_o.call_done   = done;
    res_o.lock_status = state_d.locked_proto;
    // A restart points back at F with the cleared state
    if (!done && !req_type_i) begin
      res_o.next_protocol = (state_d.sub_phase == PH_SECOND) ?
                            proto_e'(~state_d.probe_proto) : PROTO_A;
      res_o.reported_kind = KIND_TAG;
    end else begin
      res_o.reported_kind = kind;
      if (state_d.locked_proto == LOCK_A) begin
        res_o.next_protocol = PROTO_A;
      end else if (state_d.locked_proto == LOCK_F) begin
        res_o.next_protocol = PROTO_F;
      end else begin
        res_o.next_protocol = state_d.probe_proto;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/nfc_poll_protocol_lock_unit.sv */
// NFC poll protocol lock: one poll outcome or restart beat in, one decision beat out.
// The block accepts a request beat on every clock cycle while its skid stage is empty and
// returns the matching result through its output register. The lock state, probe
// protocol, sub-poll phase and three saturating debounce counters are updated once per
// accepted beat in the core, so the rate is one beat per cycle; an output stall of more than
// one beat fills the skid stage and then holds off requests until results are taken.
// Thresholds sit in three 4-bit APB registers at byte offsets 0, 4 and 8 and should be
// written only while no beat is outstanding.
module nfc_poll_protocol_lock_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  nfcpl_req_if.sink                   req_i,
  nfcpl_res_if.source                 res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nfcpl_pkg::AddrW-1:0] paddr,
  input  logic [nfcpl_pkg::DataW-1:0] pwdata,
  output logic [nfcpl_pkg::DataW-1:0] prdata,
  output logic                        pready
);
  import nfcpl_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;
  res_t     res_d;
  res_t     out_q, skid_q;
  logic     out_valid_q, skid_valid_q;
  logic     accept, take;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lock_release_count     <= LockReleaseRst;
      cfg_q.f_clean_absence_count  <= FCleanRst;
      cfg_q.f_noisy_fallback_count <= FNoisyRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LOCK_RELEASE: cfg_q.lock_release_count     <= pwdata[CtrW-1:0];
        REG_F_CLEAN:      cfg_q.f_clean_absence_count  <= pwdata[CtrW-1:0];
        REG_F_NOISY:      cfg_q.f_noisy_fallback_count <= pwdata[CtrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_LOCK_RELEASE: prdata = {{(DataW-CtrW){1'b0}}, cfg_q.lock_release_count};
      REG_F_CLEAN:      prdata = {{(DataW-CtrW){1'b0}}, cfg_q.f_clean_absence_count};
      REG_F_NOISY:      prdata = {{(DataW-CtrW){1'b0}}, cfg_q.f_noisy_fallback_count};
      default:          prdata = '0;
    endcase
  end

  assign req_i.ready = !skid_valid_q;
  assign accept      = req_i.valid && !skid_valid_q;
  assign take        = out_valid_q && res_o.ready;

  nfcpl_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .step_i         (accept),
    .req_type_i     (req_i.req_type),
    .poll_outcome_i (req_i.poll_outcome),
    .res_o          (res_d)
  );

  // Output register with a one-beat skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_valid_q && !take) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.next_protocol = out_q.next_protocol;
  assign res_o.call_done     = out_q.call_done;
  assign res_o.reported_kind = out_q.reported_kind;
  assign res_o.lock_status   = out_q.lock_status;

endmodule
